### rtl/core/rrip_dip_streaming_replacement_macros.svh
// ----------------------------------------------------------------------------
// rrip_dip_streaming_replacement_macros.svh
// Assertion helpers shared by the replacement engine RTL.
// ----------------------------------------------------------------------------
`ifndef RRIP_DIP_STREAMING_REPLACEMENT_MACROS_SVH
`define RRIP_DIP_STREAMING_REPLACEMENT_MACROS_SVH

// Checked on every clock edge, masked while reset is high.
`define RDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RDS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/rrip_dip_pkg.sv
// ----------------------------------------------------------------------------
// rrip_dip_pkg
// Types and constants of the RRIP/DIP replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rrip_dip_pkg;

  localparam int SETS       = 2048;
  localparam int WAYS       = 16;
  localparam int PSEL_WIDTH = 10;

  localparam int SET_W   = $clog2(SETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int ADDR_W  = 64;
  localparam int PC_W    = 5;
  localparam int CNT_W   = 21;
  localparam int THR_W   = 4;
  localparam int LEAD_W  = 11;
  localparam int CFG_W   = 21;
  localparam int CIDX_W  = 2;

  localparam logic [PSEL_WIDTH-1:0] PSEL_HALF = PSEL_WIDTH'(1 << (PSEL_WIDTH - 1));
  localparam logic [PSEL_WIDTH-1:0] PSEL_TOP  = '1;
  localparam logic [ADDR_W-1:0]     STRIDE    = 64'd64;

  localparam logic [1:0] RRPV_MAX   = 2'd3;
  localparam logic [1:0] RRPV_LONG  = 2'd2;
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] DEAD_MAX   = 2'd3;

  localparam logic signed [2:0] SCORE_MAX = 3'sd3;
  localparam logic signed [2:0] SCORE_MIN = -3'sd4;

  // register indexes on the config port
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] REG_PERIOD    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LEADERS   = 2'd2;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // one memory row holds all per-set state
  typedef struct packed {
    logic [WAYS-1:0][1:0] rrpv;
    logic [WAYS-1:0][1:0] dead;
    logic [ADDR_W-1:0]    prev_addr;
    logic signed [2:0]    score;
  } row_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DRD   = 5'b01000,
    S_DWR   = 5'b10000
  } state_t;

  function automatic logic [1:0] sat_dec2(input logic [1:0] v);
    return (v != 2'd0) ? v - 2'd1 : v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rrip_dip_streaming_replacement.sv
// ----------------------------------------------------------------------------
// rrip_dip_streaming_replacement
// LLC replacement engine: RRIP with stream detection, dead-block counters
// and a LIP/BIP set duel.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid/in_stall): operation 0 asks for a victim in
//    set_index, operation 1 reports a hit or fill of way_index.
//  - Result channel (out_valid/out_stall): one result per request, carrying
//    the victim way (zero for updates), victim_valid and the PSEL value.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    index 0 stream threshold, 1 decay period, 2 leader set count.
//  - A request is taken while idle and its set row comes out of the state
//    memory the next cycle; the result register loads at the end of that
//    cycle unless a stalled result holds it. A new request is taken only
//    after the read/modify/write of its row through the single port pair.
//  - When an update triggers the dead-counter decay, the block walks all
//    2048 set rows (read then write) with in_stall high.
//  - After reset a clearing pass writes every row with in_stall high;
//    config writes are taken during it.
//  - A stalled result stays in the output register; the row work for the
//    next request waits there until the result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rrip_dip_streaming_replacement
  import rrip_dip_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [SET_W-1:0]      set_index,
  input  wire logic [WAY_W-1:0]      way_index,
  input  wire logic [ADDR_W-1:0]     phys_addr,
  input  wire logic [PC_W-1:0]       pc_low,
  input  wire logic                  was_hit,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WAY_W-1:0]           victim_way,
  output logic                       victim_valid,
  output logic [PSEL_WIDTH-1:0]      duel_counter,
  // config channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CIDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

`include "rrip_dip_streaming_replacement_macros.svh"

  // config registers
  logic signed [THR_W-1:0] stream_threshold;
  logic [CNT_W-1:0]        decay_interval;
  logic [LEAD_W-1:0]       leader_sets;

  // global state
  state_t                  state, state_next;
  logic [PSEL_WIDTH-1:0]   psel, psel_next;
  logic [CNT_W-1:0]        access_count, access_count_next;
  logic [SET_W-1:0]        sweep_idx;
  logic [SET_W-1:0]        skip_set;

  // latched request
  logic                    req_op;
  logic [SET_W-1:0]        req_set;
  logic [WAY_W-1:0]        req_way;
  logic [ADDR_W-1:0]       req_addr;
  logic [PC_W-1:0]         req_pc;
  logic                    req_hit;

  // state memory
  row_t                    mem [SETS];
  row_t                    rd_row;
  logic                    rd_en;
  logic [SET_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [SET_W-1:0]        wr_addr;
  row_t                    wr_row;

  // exec datapath
  row_t                    new_row;
  row_t                    sweep_row;
  logic [WAY_W-1:0]        vic_way;
  logic [1:0]              top, lift;
  logic [ADDR_W-1:0]       delta;
  logic                    stride_hit;
  logic [1:0]              dead_line;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    decay_due;
  logic                    lip_leader, bip_leader, use_lip, streaming;
  logic [PC_W-1:0]         mix;
  logic                    any_hi, any_lo, any_max;
  logic                    exec_go;
  logic                    accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign exec_go   = (state == S_EXEC) && !(out_valid && out_stall);

  // ---- config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_threshold <= 4'sd2;
      decay_interval   <= 21'd262144;
      leader_sets      <= 11'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: stream_threshold <= signed'(cfg_data[THR_W-1:0]);
        REG_PERIOD:    decay_interval   <= cfg_data[CNT_W-1:0];
        REG_LEADERS:   leader_sets      <= cfg_data[LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- memory: one read port (registered data), one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // ---- row modify
  always_comb begin
    new_row    = rd_row;
    sweep_row  = rd_row;
    vic_way    = '0;
    any_hi     = 1'b0;
    any_lo     = 1'b0;
    any_max    = 1'b0;
    streaming  = 1'b0;
    psel_next  = psel;
    access_count_next = access_count;

    // aging: find the largest RRPV without a serial max chain
    for (int w = 0; w < WAYS; w++) begin
      any_hi  |= rd_row.rrpv[w][1];
      any_lo  |= rd_row.rrpv[w][0];
      any_max |= &rd_row.rrpv[w];
    end
    top  = any_hi ? {1'b1, any_max} : {1'b0, any_lo};
    lift = RRPV_MAX - top;

    delta      = req_addr - rd_row.prev_addr;
    stride_hit = (delta == STRIDE) || (delta == (~STRIDE + 64'd1));
    dead_line  = rd_row.dead[req_way];
    cnt_inc    = access_count + 1'b1;
    decay_due  = (decay_interval != '0) && (cnt_inc >= decay_interval);
    mix        = req_pc ^ req_addr[PC_W-1:0];
    lip_leader = req_set < leader_sets;
    bip_leader = !lip_leader && ({1'b0, req_set} < {leader_sets, 1'b0});
    use_lip    = lip_leader || (!bip_leader && (psel < PSEL_HALF));

    if (req_op == OP_VICTIM) begin
      for (int w = 0; w < WAYS; w++) begin
        new_row.rrpv[w] = rd_row.rrpv[w] + lift;
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (new_row.rrpv[w] == RRPV_MAX) vic_way = WAY_W'(w);
      end
    end else begin
      access_count_next = cnt_inc;
      if (stride_hit) begin
        if (rd_row.score != SCORE_MAX) new_row.score = rd_row.score + 3'sd1;
      end else if (delta != '0) begin
        if (rd_row.score != SCORE_MIN) new_row.score = rd_row.score - 3'sd1;
      end
      new_row.prev_addr = req_addr;

      if (req_hit) dead_line = sat_dec2(dead_line);
      else if (dead_line != DEAD_MAX) dead_line = dead_line + 2'd1;
      new_row.dead[req_way] = dead_line;

      if (decay_due) begin
        for (int w = 0; w < WAYS; w++) begin
          new_row.dead[w] = sat_dec2(new_row.dead[w]);
        end
        access_count_next = '0;
      end

      streaming = $signed({new_row.score[2], new_row.score}) >= stream_threshold;

      if (streaming) begin
        new_row.rrpv[req_way] = (mix[2:0] != 3'd0) ? RRPV_MAX : RRPV_LONG;
        if (bip_leader && !req_hit && psel != PSEL_TOP) psel_next = psel + 1'b1;
      end else if (new_row.dead[req_way] == 2'd0) begin
        new_row.rrpv[req_way] = RRPV_NEAR;
        if (lip_leader && !req_hit && psel != '0) psel_next = psel - 1'b1;
      end else if (use_lip) begin
        new_row.rrpv[req_way] = RRPV_LONG;
      end else begin
        new_row.rrpv[req_way] = (mix != '0) ? RRPV_LONG : RRPV_NEAR;
      end
    end

    for (int w = 0; w < WAYS; w++) begin
      sweep_row.dead[w] = sat_dec2(rd_row.dead[w]);
    end
  end

  // ---- memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = set_index;
    wr_en   = 1'b0;
    wr_addr = req_set;
    wr_row  = new_row;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx;
        wr_row  = '{rrpv: {WAYS{RRPV_LONG}}, dead: '0, prev_addr: '0, score: '0};
      end
      S_IDLE: begin
        rd_en = accept;
      end
      S_EXEC: begin
        wr_en = exec_go;
      end
      S_DRD: begin
        rd_en   = 1'b1;
        rd_addr = sweep_idx;
      end
      S_DWR: begin
        // the updated set was already decayed in its own write
        wr_en   = (sweep_idx != skip_set);
        wr_addr = sweep_idx;
        wr_row  = sweep_row;
      end
      default: ;
    endcase
  end

  // ---- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sweep_idx == SET_W'(SETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC: begin
        if (exec_go) begin
          state_next = (req_op == OP_UPDATE && decay_due) ? S_DRD : S_IDLE;
        end
      end
      S_DRD:   state_next = S_DWR;
      S_DWR:   state_next = (sweep_idx == SET_W'(SETS - 1)) ? S_IDLE : S_DRD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep_idx    <= '0;
      psel         <= PSEL_HALF;
      access_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR || state == S_DWR) begin
        sweep_idx <= sweep_idx + 1'b1;
      end else if (state == S_EXEC) begin
        sweep_idx <= '0;
      end
      if (exec_go) begin
        psel         <= psel_next;
        access_count <= access_count_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= operation;
      req_set  <= set_index;
      req_way  <= way_index;
      req_addr <= phys_addr;
      req_pc   <= pc_low;
      req_hit  <= was_hit;
    end
    if (exec_go) begin
      skip_set     <= req_set;
      victim_way   <= vic_way;
      victim_valid <= (req_op == OP_VICTIM);
      duel_counter <= psel_next;
    end
  end

  // ---- checks
  `RDS_ASSERT_ALWAYS(a_reset_clears, rst |=> state == S_CLEAR, "reset did not start clearing")
  `RDS_ASSERT(a_accept_exec, accept |=> state == S_EXEC, "accepted request not executed")
  `RDS_ASSERT(a_result_from_exec, $rose(out_valid) |-> $past(state == S_EXEC), "stray result")
  `RDS_ASSERT(a_psel_step, (psel == $past(psel)) || (psel == $past(psel) + 1'b1) || (psel == $past(psel) - 1'b1), "PSEL jumped")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// RRIP/DIP replacement engine testbench
// Drives victim and update requests into the engine and predicts each result
// with a behavioral copy of the RRPV, dead-counter, stream-score and PSEL
// state. Results are checked in order against that prediction, under random
// idling on both channels and across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rrip_dip_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;  // decay sweep plus worst stalls, many times over
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_PAUSE    = 8;

  typedef struct packed {
    logic [WAY_W-1:0]      way;
    logic                  is_victim;
    logic [PSEL_WIDTH-1:0] psel;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  operation = OP_VICTIM;
  logic [SET_W-1:0]      set_index = '0;
  logic [WAY_W-1:0]      way_index = '0;
  logic [ADDR_W-1:0]     phys_addr = '0;
  logic [PC_W-1:0]       pc_low = '0;
  logic                  was_hit = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WAY_W-1:0]      victim_way;
  logic                  victim_valid;
  logic [PSEL_WIDTH-1:0] duel_counter;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CIDX_W-1:0]     cfg_index = REG_THRESHOLD;
  logic [CFG_W-1:0]      cfg_data = '0;

  rrip_dip_streaming_replacement uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted engine state
  // ---------------------------------------------------------------------------
  logic [1:0]            rrpv_m   [SETS][WAYS];
  logic [1:0]            dead_m   [SETS][WAYS];
  logic [ADDR_W-1:0]     last_m   [SETS];
  logic signed [2:0]     score_m  [SETS];
  logic [PSEL_WIDTH-1:0] psel_m;
  logic [CNT_W-1:0]      count_m;
  logic signed [THR_W-1:0] thresh_m;
  logic [CNT_W-1:0]      period_m;
  logic [LEAD_W-1:0]     leaders_m;

  result_t pending_results[$];

  int errors = 0;
  int n_victims = 0, n_updates = 0, n_decays = 0, n_results = 0;
  int psel_lo = 1 << PSEL_WIDTH, psel_hi = 0;
  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // ask the receiver for one long hold

  task automatic reset_model();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        rrpv_m[s][w] = RRPV_LONG;
        dead_m[s][w] = 2'd0;
      end
      last_m[s]  = '0;
      score_m[s] = 3'sd0;
    end
    psel_m    = PSEL_HALF;
    count_m   = '0;
    thresh_m  = 4'sd2;
    period_m  = 21'd262144;
    leaders_m = 11'd32;
  endtask

  // victim pick: age the set until the oldest line sits at RRPV 3
  function automatic logic [WAY_W-1:0] choose_victim(int s);
    logic [1:0] top;
    top = 2'd0;
    for (int w = 0; w < WAYS; w++)
      if (rrpv_m[s][w] > top) top = rrpv_m[s][w];
    if (top < RRPV_MAX)
      for (int w = 0; w < WAYS; w++) rrpv_m[s][w] = rrpv_m[s][w] + (RRPV_MAX - top);
    for (int w = 0; w < WAYS; w++)
      if (rrpv_m[s][w] == RRPV_MAX) return WAY_W'(w);
    return '0;
  endfunction

  function automatic void train_line(int s, int w, logic [ADDR_W-1:0] addr,
                                     logic [PC_W-1:0] pc, logic hit);
    logic [ADDR_W-1:0] delta;
    logic [PC_W-1:0]   mix;
    bit lip_lead, bip_lead, use_lip, streaming;
    delta    = addr - last_m[s];
    mix      = pc ^ addr[PC_W-1:0];
    lip_lead = s < int'(leaders_m);
    bip_lead = !lip_lead && s < 2 * int'(leaders_m);
    count_m  = count_m + 1'b1;
    if (delta == STRIDE || delta == -STRIDE) begin
      if (score_m[s] < SCORE_MAX) score_m[s] = score_m[s] + 3'sd1;
    end else if (delta != '0) begin
      if (score_m[s] > SCORE_MIN) score_m[s] = score_m[s] - 3'sd1;
    end
    last_m[s] = addr;
    if (hit) begin
      if (dead_m[s][w] != 2'd0) dead_m[s][w] = dead_m[s][w] - 2'd1;
    end else if (dead_m[s][w] != DEAD_MAX) begin
      dead_m[s][w] = dead_m[s][w] + 2'd1;
    end
    // global decay sweep
    if (period_m != '0 && count_m >= period_m) begin
      for (int i = 0; i < SETS; i++)
        for (int j = 0; j < WAYS; j++)
          if (dead_m[i][j] != 2'd0) dead_m[i][j] = dead_m[i][j] - 2'd1;
      count_m = '0;
      n_decays++;
    end
    if (lip_lead)      use_lip = 1'b1;
    else if (bip_lead) use_lip = 1'b0;
    else               use_lip = psel_m < PSEL_HALF;
    streaming = $signed({score_m[s][2], score_m[s]}) >= thresh_m;
    // insertion: streaming first, then dead-line near insert, then the duel
    if (streaming) begin
      rrpv_m[s][w] = (mix[2:0] != 3'd0) ? RRPV_MAX : RRPV_LONG;
      if (bip_lead && !hit && psel_m != PSEL_TOP) psel_m = psel_m + 1'b1;
    end else if (dead_m[s][w] == 2'd0) begin
      rrpv_m[s][w] = RRPV_NEAR;
      if (lip_lead && !hit && psel_m != '0) psel_m = psel_m - 1'b1;
    end else if (use_lip) begin
      rrpv_m[s][w] = RRPV_LONG;
    end else begin
      rrpv_m[s][w] = (mix != '0) ? RRPV_LONG : RRPV_NEAR;
    end
  endfunction

  function automatic result_t predict_request(logic op, logic [SET_W-1:0] s,
                                              logic [WAY_W-1:0] w, logic [ADDR_W-1:0] addr,
                                              logic [PC_W-1:0] pc, logic hit);
    result_t r;
    r = '0;
    if (op == OP_VICTIM) begin
      r.way = choose_victim(int'(s));
      r.is_victim = 1'b1;
      n_victims++;
    end else begin
      train_line(int'(s), int'(w), addr, pc, hit);
      n_updates++;
    end
    r.psel = psel_m;
    if (int'(psel_m) < psel_lo) psel_lo = int'(psel_m);
    if (int'(psel_m) > psel_hi) psel_hi = int'(psel_m);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_request(logic op, logic [SET_W-1:0] s, logic [WAY_W-1:0] w,
                              logic [ADDR_W-1:0] addr, logic [PC_W-1:0] pc, logic hit);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    set_index <= s;
    way_index <= w;
    phys_addr <= addr;
    pc_low    <= pc;
    was_hit   <= hit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_request(op, s, w, addr, pc, hit));
  endtask

  // stop offering and wait for every outstanding result (and any decay sweep)
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    while (in_stall) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_THRESHOLD: thresh_m  = data[THR_W-1:0];
      REG_PERIOD:    period_m  = data[CNT_W-1:0];
      REG_LEADERS:   leaders_m = data[LEAD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [SET_W-1:0] pick_set();
    int l;
    l = int'(leaders_m);
    case ($urandom_range(0, 4))
      0:       return SET_W'($urandom_range(0, 7));
      1:       return SET_W'(l + $urandom_range(0, 3) - 2);  // LIP/BIP boundary
      2:       return SET_W'(2 * l + $urandom_range(0, 3) - 2);
      3:       return SET_W'($urandom_range(SETS - 8, SETS - 1));
      default: return SET_W'($urandom);
    endcase
  endfunction

  // mostly stride runs within a set, with noise mixed in
  task automatic random_request();
    logic [SET_W-1:0]  s;
    logic [ADDR_W-1:0] addr;
    int kind;
    s    = pick_set();
    kind = $urandom_range(0, 19);
    if (kind < 10)      addr = last_m[s] + STRIDE;
    else if (kind < 13) addr = last_m[s] - STRIDE;
    else if (kind < 14) addr = last_m[s];
    else                addr = {$urandom, $urandom};
    send_request(($urandom_range(0, 9) < 3) ? OP_VICTIM : OP_UPDATE, s,
                 WAY_W'($urandom), addr, PC_W'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, one long hold on request
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left <= LONG_HOLD - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: way %0d valid %0d psel %0d",
               victim_way, victim_valid, duel_counter);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (victim_way !== want.way) begin
          $error("victim_way: expected %0d, got %0d", want.way, victim_way);
          errors++;
        end
        if (victim_valid !== want.is_victim) begin
          $error("victim_valid: expected %0d, got %0d", want.is_victim, victim_valid);
          errors++;
        end
        if (duel_counter !== want.psel) begin
          $error("duel_counter: expected %0d, got %0d", want.psel, duel_counter);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // field extremes, stride wrap, hit and fill, victim on a fresh set
  task automatic test_corners();
    send_request(OP_VICTIM, '0, '0, '0, '0, 1'b0);          // all RRPV 2: age to 3, way 0
    send_request(OP_UPDATE, '0, '1, 64'd64, '1, 1'b0);      // +64 stride, fill
    send_request(OP_UPDATE, '0, '0, 64'd128, '0, 1'b1);     // stride again, hit
    send_request(OP_UPDATE, '0, '0, 64'd128, 5'h1F, 1'b0);  // zero delta
    send_request(OP_VICTIM, '0, '1, '1, '1, 1'b1);
    send_request(OP_UPDATE, '1, '1, '1, 5'h1F, 1'b0);       // largest address
    send_request(OP_UPDATE, '1, 4'd7, '0, '0, 1'b0);        // delta wraps to +1
    send_request(OP_UPDATE, '1, 4'd7, -STRIDE, '0, 1'b1);   // wraps to -64 from zero
    send_request(OP_UPDATE, '1, 4'd8, '0, 5'h07, 1'b0);     // +64 across zero
    send_request(OP_VICTIM, '1, '0, '0, '0, 1'b0);
    send_request(OP_UPDATE, 11'd31, 4'd3, 64'h5555_5555_5555_5555, 5'h15, 1'b0);  // last LIP
    send_request(OP_UPDATE, 11'd32, 4'd3, 64'hAAAA_AAAA_AAAA_AAAA, 5'h0A, 1'b0);  // first BIP
    send_request(OP_UPDATE, 11'd63, 4'd12, 64'h8000_0000_0000_0000, 5'h10, 1'b0); // last BIP
    send_request(OP_UPDATE, 11'd64, 4'd12, 64'h0000_0000_0000_0020, 5'h00, 1'b0); // follower
    send_request(OP_VICTIM, 11'd64, '0, '0, '0, 1'b0);
    send_request(OP_VICTIM, 11'd64, '0, '0, '0, 1'b0);       // second pick, no aging needed
    send_request(OP_UPDATE, 11'd1024, 4'd9, 64'h40, 5'h1F, 1'b1);
    drain_results();
  endtask

  // requests only to BIP leader sets and every update streaming: PSEL climbs to the top
  task automatic test_psel_ceiling();
    write_reg(REG_THRESHOLD, CFG_W'(4'hC));   // -4, everything streams
    write_reg(REG_LEADERS, CFG_W'(0));
    send_request(OP_UPDATE, 11'd3, 4'd2, 64'h1234, 5'h3, 1'b0);  // no leaders at all
    drain_results();
    write_reg(REG_LEADERS, CFG_W'(1024));     // all of [1024,2048) are BIP leaders
    for (int i = 0; i < 530; i++)
      send_request(OP_UPDATE, SET_W'($urandom_range(1024, SETS - 1)), WAY_W'($urandom),
                   {$urandom, $urandom}, PC_W'($urandom), 1'b0);
    drain_results();
  endtask

  // decay every update drives dead counters to zero, so LIP leader fills pull PSEL down
  task automatic test_decay();
    write_reg(REG_THRESHOLD, CFG_W'(4'h4));   // +4: nothing streams
    write_reg(REG_PERIOD, CFG_W'(1));
    for (int i = 0; i < 4; i++)
      send_request(OP_UPDATE, SET_W'($urandom_range(0, 1023)), WAY_W'(i), {$urandom, $urandom},
                   PC_W'($urandom), 1'b0);
    drain_results();
    write_reg(REG_PERIOD, CFG_W'(0));         // decay disabled
    for (int i = 0; i < 6; i++) random_request();
    drain_results();
    write_reg(REG_PERIOD, CFG_W'(21'h100000));
    write_reg(REG_THRESHOLD, CFG_W'(4'hF));   // -1
    for (int i = 0; i < 12; i++) random_request();
    drain_results();
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all results
  task automatic test_backpressure();
    write_reg(REG_THRESHOLD, CFG_W'(4'h3));
    write_reg(REG_LEADERS, CFG_W'(2047));
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) random_request();
    drain_results();
    for (int i = 0; i < 10; i++) random_request();
    drain_results();
  endtask

  // bulk random traffic over several settings; last stretch without idling
  task automatic test_random();
    write_reg(REG_THRESHOLD, CFG_W'(4'h2));
    write_reg(REG_PERIOD, CFG_W'(37));
    write_reg(REG_LEADERS, CFG_W'(32));
    for (int i = 0; i < 180; i++) random_request();
    drain_results();
    write_reg(REG_THRESHOLD, CFG_W'(4'h0));
    write_reg(REG_PERIOD, CFG_W'(5));
    write_reg(REG_LEADERS, CFG_W'(1023));
    for (int i = 0; i < 120; i++) random_request();
    drain_results();
    write_reg(REG_THRESHOLD, CFG_W'(4'h1));
    write_reg(REG_PERIOD, CFG_W'(61));
    write_reg(REG_LEADERS, CFG_W'(8));
    for (int i = 0; i < 30; i++) random_request();
    quiet = 1'b1;
    for (int i = 0; i < 100; i++) random_request();
    drain_results();
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_corners();
    test_psel_ceiling();
    test_decay();
    test_backpressure();
    test_random();

    $display("covered %0d victim and %0d update requests, %0d results, %0d decay sweeps",
             n_victims, n_updates, n_results, n_decays);
    $display("PSEL ranged %0d..%0d over thresholds -4..4 and 0..1024+ leader sets",
             psel_lo, psel_hi);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rrip_dip_pkg.sv
rtl/core/rrip_dip_streaming_replacement.sv
sim/testbench.sv
